@@ rtl/utf8af_pkg.sv @@
// Package for the UTF-8 accent folder: pending-prefix codes, the decode
// result bundle and the fold table for C3 pairs. No dependencies.
`timescale 1ns / 1ps

package utf8af_pkg;

	localparam int unsigned MaxOut = 3;
	localparam int unsigned CntW   = $clog2(MaxOut + 1);

	localparam logic [7:0] BYTE_C3    = 8'hC3;
	localparam logic [7:0] BYTE_C5    = 8'hC5;
	localparam logic [7:0] BYTE_E2    = 8'hE2;
	localparam logic [7:0] BYTE_80    = 8'h80;
	localparam logic [7:0] BYTE_99    = 8'h99;
	localparam logic [7:0] BYTE_92    = 8'h92;
	localparam logic [7:0] BYTE_93    = 8'h93;
	localparam logic [7:0] CHAR_UP_O  = 8'h4F;
	localparam logic [7:0] CHAR_UP_E  = 8'h45;
	localparam logic [7:0] CHAR_LO_O  = 8'h6F;
	localparam logic [7:0] CHAR_LO_E  = 8'h65;
	localparam logic [7:0] CHAR_APOS  = 8'h27;

	// Pending lead byte, one-hot
	typedef enum logic [3:0] {
		LEAD_NONE = 4'b0001,
		LEAD_C3   = 4'b0010,
		LEAD_C5   = 4'b0100,
		LEAD_E2   = 4'b1000
	} lead_t;

	typedef struct packed {
		logic [MaxOut-1:0][7:0] bytes;
		logic [CntW-1:0]        cnt;
		lead_t                  lead;
		logic                   cont;
	} fold_res_t;

	// Second byte after C3, offset from 0x80; zero means no fold
	function automatic logic [7:0] fold_c3(input logic [5:0] idx);
		logic [7:0] f;
		unique case (idx) inside
			[6'h00:6'h05]: f = 8'h41; // A
			6'h07:         f = 8'h43; // C
			[6'h08:6'h0B]: f = 8'h45; // E
			[6'h0C:6'h0F]: f = 8'h49; // I
			[6'h12:6'h16]: f = 8'h4F; // O
			[6'h19:6'h1C]: f = 8'h55; // U
			[6'h20:6'h25]: f = 8'h61; // a
			6'h27:         f = 8'h63; // c
			[6'h28:6'h2B]: f = 8'h65; // e
			[6'h2C:6'h2F]: f = 8'h69; // i
			[6'h32:6'h36]: f = 8'h6F; // o
			[6'h39:6'h3C]: f = 8'h75; // u
			6'h3F:         f = 8'h79; // y
			default:       f = 8'h00;
		endcase
		return f;
	endfunction

endpackage

@@ rtl/utf8af_decode.sv @@
// Combinational decode of one byte against the pending prefix.
// Depends on utf8af_pkg.
`timescale 1ns / 1ps

module utf8af_decode import utf8af_pkg::*; (
	input  logic [7:0] in_byte,
	input  logic       text_end,
	input  lead_t      lead,
	input  logic       cont,
	output fold_res_t  res
);

	logic       fr_open;
	lead_t      fr_lead;
	logic [7:0] fold_val;

	// Byte seen with nothing pending: open a prefix unless at end of text
	always_comb begin
		fr_open = 1'b0;
		fr_lead = LEAD_NONE;
		if (!text_end) begin
			if (in_byte == BYTE_C3) begin
				fr_open = 1'b1;
				fr_lead = LEAD_C3;
			end else if (in_byte == BYTE_C5) begin
				fr_open = 1'b1;
				fr_lead = LEAD_C5;
			end else if (in_byte == BYTE_E2) begin
				fr_open = 1'b1;
				fr_lead = LEAD_E2;
			end
		end
	end

	assign fold_val = (in_byte[7:6] == 2'b10) ? fold_c3(in_byte[5:0]) : 8'h00;

	always_comb begin
		res.bytes = '0;
		res.cnt   = '0;
		res.lead  = LEAD_NONE;
		res.cont  = 1'b0;
		unique case (lead)
			LEAD_NONE: begin
				if (fr_open) begin
					res.lead = fr_lead;
				end else begin
					res.bytes[0] = in_byte;
					res.cnt      = CntW'(1);
				end
			end
			LEAD_C3: begin
				if (fold_val != 8'h00) begin
					res.bytes[0] = fold_val;
					res.cnt      = CntW'(1);
				end else begin
					res.bytes[0] = BYTE_C3;
					res.bytes[1] = in_byte;
					res.cnt      = CntW'(2);
				end
			end
			LEAD_C5: begin
				if (in_byte == BYTE_92) begin
					res.bytes[0] = CHAR_UP_O;
					res.bytes[1] = CHAR_UP_E;
					res.cnt      = CntW'(2);
				end else if (in_byte == BYTE_93) begin
					res.bytes[0] = CHAR_LO_O;
					res.bytes[1] = CHAR_LO_E;
					res.cnt      = CntW'(2);
				end else begin
					res.bytes[0] = BYTE_C5;
					if (fr_open) begin
						res.lead = fr_lead;
						res.cnt  = CntW'(1);
					end else begin
						res.bytes[1] = in_byte;
						res.cnt      = CntW'(2);
					end
				end
			end
			LEAD_E2: begin
				if (!cont) begin
					if (in_byte == BYTE_80 && !text_end) begin
						res.lead = LEAD_E2;
						res.cont = 1'b1;
					end else if (in_byte == BYTE_80) begin
						res.bytes[0] = BYTE_E2;
						res.bytes[1] = BYTE_80;
						res.cnt      = CntW'(2);
					end else begin
						res.bytes[0] = BYTE_E2;
						if (fr_open) begin
							res.lead = fr_lead;
							res.cnt  = CntW'(1);
						end else begin
							res.bytes[1] = in_byte;
							res.cnt      = CntW'(2);
						end
					end
				end else if (in_byte == BYTE_99) begin
					res.bytes[0] = CHAR_APOS;
					res.cnt      = CntW'(1);
				end else begin
					res.bytes[0] = BYTE_E2;
					res.bytes[1] = BYTE_80;
					if (fr_open) begin
						res.lead = fr_lead;
						res.cnt  = CntW'(2);
					end else begin
						res.bytes[2] = in_byte;
						res.cnt      = CntW'(3);
					end
				end
			end
			default: begin
				res.lead = LEAD_NONE;
			end
		endcase
	end

endmodule

@@ rtl/utf8_accent_folding.sv @@
// Top level of the UTF-8 accent folder: input register, decode, result buffer.
// Depends on utf8af_pkg and utf8af_decode.
`timescale 1ns / 1ps

//  channel | handshake           | payload
//  --------+---------------------+------------------------------
//  input   | in_valid / in_ready | in_byte, text_end
//  output  | out_valid/out_ready | out_byte, run_last, out_end
//
// One byte enters per cycle while the output is not stalled; a byte that yields
// one result or none keeps that pace. A byte that yields two or three results
// holds the input while the result buffer drains one byte a cycle, unless the output stalls.
// From input accept to the first result an item passes the input register and the result buffer.
// Reset clears the pending prefix and empties both stages.
// A stalled output holds the buffer; the input register still takes an item while it is empty.

module utf8_accent_folding import utf8af_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       text_end,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       run_last,
	output logic       out_end
);

	// Input register stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       end_s1;

	// Pending prefix state
	lead_t lead_q;
	logic  cont_q;

	// Result buffer: bytes shift down as they leave, rem_q counts what remains
	logic [MaxOut-1:0][7:0] buf_q;
	logic [CntW-1:0]        rem_q;
	logic                   end_q;

	fold_res_t res;
	logic      pop;
	logic      buf_free;
	logic      adv;

	utf8af_decode u_decode (
		.in_byte  (byte_s1),
		.text_end (end_s1),
		.lead     (lead_q),
		.cont     (cont_q),
		.res      (res)
	);

	assign out_valid = (rem_q != '0);
	assign out_byte  = buf_q[0];
	assign run_last  = (rem_q == CntW'(1));
	assign out_end   = run_last & end_q;

	assign pop      = out_valid & out_ready;
	// Buffer takes a new group once empty or when its last byte leaves now
	assign buf_free = (rem_q == '0) || (run_last && out_ready);
	assign adv      = valid_s1 & buf_free;
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
			end_s1  <= text_end;
		end
	end

	// Advance the prefix state as each item leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_q <= LEAD_NONE;
			cont_q <= 1'b0;
		end else if (adv) begin
			lead_q <= res.lead;
			cont_q <= res.cont;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (adv) begin
			rem_q <= res.cnt;
		end else if (pop) begin
			rem_q <= rem_q - CntW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			buf_q <= res.bytes;
			end_q <= end_s1;
		end else if (pop) begin
			buf_q <= {8'h00, buf_q[MaxOut-1:1]};
		end
	end

	// A continuation flag only exists under a pending E2
	a_cont_lead: assert property (@(posedge clk) disable iff (!arst_n)
		cont_q |-> (lead_q == LEAD_E2))
		else $error("continuation flag set without pending E2");

	// The final byte of a text leaves with no prefix pending
	a_end_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && out_end) |-> (lead_q == LEAD_NONE && !cont_q))
		else $error("prefix pending at end of text");

	// A held input register keeps its item
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv) |=> (valid_s1 && $stable(byte_s1) && $stable(end_s1)))
		else $error("input register lost a held item");

	// The buffer never holds more than its capacity
	a_rem_max: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q <= CntW'(MaxOut))
		else $error("result buffer count out of range");

endmodule

@@ tb/utf8_accent_folding_checker.sv @@
// Checker for the UTF-8 accent folder: watches both channels, predicts the
// folded bytes of every accepted input item and compares them in order.
// Depends on utf8af_pkg for the pending-prefix codes and byte constants.
`timescale 1ns / 1ps

module utf8_accent_folding_checker import utf8af_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       text_end,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [7:0] out_byte,
	input  logic       run_last,
	input  logic       out_end,
	output int         fail_count,
	output int         waiting
);

	typedef struct packed {
		logic [7:0] ch;
		logic       run_done;
		logic       text_done;
	} folded_t;

	folded_t    fold_expect[$];
	logic [7:0] run_bytes[$];
	lead_t      open_lead;
	logic       e2_has_80;
	int         mism;

	// Plain letter for the byte after C3; zero when it is not a folded letter
	function automatic logic [7:0] plain_letter(input logic [7:0] b);
		logic [7:0] p;
		p = 8'h00;
		if (b >= 8'h80 && b <= 8'h85)      p = 8'h41; // A
		else if (b == 8'h87)               p = 8'h43; // C
		else if (b >= 8'h88 && b <= 8'h8B) p = 8'h45; // E
		else if (b >= 8'h8C && b <= 8'h8F) p = 8'h49; // I
		else if (b >= 8'h92 && b <= 8'h96) p = 8'h4F; // O
		else if (b >= 8'h99 && b <= 8'h9C) p = 8'h55; // U
		else if (b >= 8'hA0 && b <= 8'hA5) p = 8'h61; // a
		else if (b == 8'hA7)               p = 8'h63; // c
		else if (b >= 8'hA8 && b <= 8'hAB) p = 8'h65; // e
		else if (b >= 8'hAC && b <= 8'hAF) p = 8'h69; // i
		else if (b >= 8'hB2 && b <= 8'hB6) p = 8'h6F; // o
		else if (b >= 8'hB9 && b <= 8'hBC) p = 8'h75; // u
		else if (b == 8'hBF)               p = 8'h79; // y
		return p;
	endfunction

	// Append one byte to the run of the current item
	task automatic emit_byte(input logic [7:0] b);
		run_bytes = {run_bytes, b};
	endtask

	// Byte seen with no prefix open: open one, or emit it
	task automatic take_fresh(input logic [7:0] b, input logic fin);
		if (!fin && b == BYTE_C3) begin
			open_lead = LEAD_C3;
		end else if (!fin && b == BYTE_C5) begin
			open_lead = LEAD_C5;
		end else if (!fin && b == BYTE_E2) begin
			open_lead = LEAD_E2;
			e2_has_80 = 1'b0;
		end else begin
			emit_byte(b);
		end
	endtask

	task automatic predict_fold(input logic [7:0] b, input logic fin);
		lead_t      was_lead;
		logic       was_80;
		logic [7:0] plain;
		folded_t    r;
		was_lead = open_lead;
		was_80 = e2_has_80;
		open_lead = LEAD_NONE;
		e2_has_80 = 1'b0;
		run_bytes.delete();
		case (was_lead)
			LEAD_C3: begin
				plain = plain_letter(b);
				if (plain != 8'h00) begin
					emit_byte(plain);
				end else begin
					emit_byte(BYTE_C3);
					emit_byte(b);
				end
			end
			LEAD_C5: begin
				if (b == BYTE_92) begin
					emit_byte(CHAR_UP_O);
					emit_byte(CHAR_UP_E);
				end else if (b == BYTE_93) begin
					emit_byte(CHAR_LO_O);
					emit_byte(CHAR_LO_E);
				end else begin
					emit_byte(BYTE_C5);
					take_fresh(b, fin);
				end
			end
			LEAD_E2: begin
				if (!was_80) begin
					if (b == BYTE_80 && !fin) begin
						open_lead = LEAD_E2;
						e2_has_80 = 1'b1;
					end else if (b == BYTE_80) begin
						emit_byte(BYTE_E2);
						emit_byte(BYTE_80);
					end else begin
						emit_byte(BYTE_E2);
						take_fresh(b, fin);
					end
				end else if (b == BYTE_99) begin
					emit_byte(CHAR_APOS);
				end else begin
					emit_byte(BYTE_E2);
					emit_byte(BYTE_80);
					take_fresh(b, fin);
				end
			end
			default: take_fresh(b, fin);
		endcase
		if (fin) begin
			open_lead = LEAD_NONE;
			e2_has_80 = 1'b0;
		end
		foreach (run_bytes[k]) begin
			r.ch = run_bytes[k];
			r.run_done = (k == run_bytes.size() - 1);
			r.text_done = fin && (k == run_bytes.size() - 1);
			fold_expect = {fold_expect, r};
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		folded_t want;
		if (!arst_n) begin
			open_lead = LEAD_NONE;
			e2_has_80 = 1'b0;
			fold_expect.delete();
			mism = 0;
		end else begin
			if (in_valid && in_ready)
				predict_fold(in_byte, text_end);
			if (out_valid && out_ready) begin
				if (fold_expect.size() == 0) begin
					mism = mism + 1;
					$display("%0t: unexpected result, expected none, %s %h run_last %b end %b",
						$time, "got byte", out_byte, run_last, out_end);
				end else begin
					want = fold_expect.pop_front();
					if (want.ch !== out_byte || want.run_done !== run_last ||
							want.text_done !== out_end) begin
						mism = mism + 1;
						$display("%0t: expected byte %h run_last %b end %b, %s",
							$time, want.ch, want.run_done, want.text_done, "got");
						$display("%0t:   actual byte %h run_last %b end %b",
							$time, out_byte, run_last, out_end);
					end
				end
			end
		end
		fail_count <= mism;
		waiting <= fold_expect.size();
	end

endmodule

@@ tb/utf8_accent_folding_tb.sv @@
// Testbench top for utf8_accent_folding: clock, reset, byte stimulus with
// random idling on both channels, and the final verdict.
// Depends on the RTL, utf8af_pkg and utf8_accent_folding_checker.
`timescale 1ns / 1ps

module utf8_accent_folding_tb import utf8af_pkg::*;;

	// cycles with no accept on either channel before the run is declared hung;
	// the slowest legal wait is a sender gap plus a receiver stall plus the
	// input register and result buffer, so this is many times over
	localparam int IdleLimit = 400;
	// quiet cycles after the last result, to catch stray late results
	localparam int TailWait = 12;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic [7:0] in_byte = 8'h00;
	logic       text_end = 1'b0;
	logic       out_ready = 1'b0;
	logic       in_ready;
	logic       out_valid;
	logic [7:0] out_byte;
	logic       run_last;
	logic       out_end;

	int fail_count;
	int waiting;

	// prepared text, one entry per input item
	logic [7:0] text_bytes[$];
	logic       text_fins[$];
	int         n_items = 0;
	int         quiet_from = 0;
	bit         text_built = 1'b0;

	int item_idx = 0;
	int gap_left = 0;
	int stall_left = 0;
	int idle_cycles = 0;

	always #5 clk = ~clk;

	utf8_accent_folding dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_byte   (in_byte),
		.text_end  (text_end),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.run_last  (run_last),
		.out_end   (out_end)
	);

	utf8_accent_folding_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_byte    (in_byte),
		.text_end   (text_end),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.run_last   (run_last),
		.out_end    (out_end),
		.fail_count (fail_count),
		.waiting    (waiting)
	);

	task automatic add_item(input logic [7:0] b, input logic fin);
		text_bytes = {text_bytes, b};
		text_fins = {text_fins, fin};
	endtask

	// random end-of-text flag: roughly one byte in fifteen closes the text,
	// prefix bytes included, so flushes land in every pending state
	function automatic logic rand_fin();
		return ($urandom_range(0, 14) == 0);
	endfunction

	// Sender: hold the item until accepted, then advance or idle for a burst.
	// The decision is made only once the current item is gone, so valid is
	// assigned once per edge and never drops under a waiting item.
	always @(posedge clk) begin
		int nxt;
		if (arst_n && text_built) begin
			nxt = item_idx + ((in_valid && in_ready) ? 1 : 0);
			item_idx <= nxt;
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					in_valid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (nxt < n_items) begin
					// every third stretch of 40 items runs with no gaps
					if (nxt < quiet_from && (nxt / 40) % 3 != 2 &&
							$urandom_range(0, 5) == 0) begin
						in_valid <= 1'b0;
						gap_left <= $urandom_range(0, 14);
					end else begin
						in_valid <= 1'b1;
						in_byte <= text_bytes[nxt];
						text_end <= text_fins[nxt];
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: stall in bursts, except in the quiet tail of the run.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (item_idx < quiet_from && $urandom_range(0, 5) == 0) begin
			out_ready <= 1'b0;
			stall_left <= $urandom_range(0, 14);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Watchdog: count cycles in which neither channel moves an item.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("utf8_accent_folding verification failed");
			$finish;
		end
	end

	initial begin
		int      kind;
		int      pick;
		bit      clean;
		// Directed text: extremes, every prefix kind, broken sequences and
		// flushes at end of text.
		add_item(8'h00, 1'b0);
		add_item(8'hFF, 1'b0);               // high byte that opens nothing
		add_item(BYTE_C3, 1'b0);
		add_item(8'h80, 1'b0);               // first folded letter
		add_item(BYTE_C3, 1'b0);
		add_item(8'h9F, 1'b0);               // sharp s passes as two bytes
		add_item(BYTE_C3, 1'b0);
		add_item(8'hBF, 1'b0);               // last folded letter
		add_item(BYTE_C3, 1'b0);
		add_item(BYTE_C5, 1'b0);             // any byte is taken as the partner
		add_item(BYTE_C5, 1'b0);
		add_item(BYTE_92, 1'b0);
		add_item(BYTE_C5, 1'b0);
		add_item(BYTE_93, 1'b0);
		add_item(BYTE_C5, 1'b0);             // unmatched, E2 starts anew
		add_item(BYTE_E2, 1'b0);
		add_item(BYTE_80, 1'b0);
		add_item(BYTE_99, 1'b0);
		add_item(BYTE_E2, 1'b0);
		add_item(8'h41, 1'b0);               // E2 broken after one byte
		add_item(BYTE_E2, 1'b0);
		add_item(BYTE_80, 1'b0);
		add_item(BYTE_C3, 1'b1);             // three bytes flushed at the end
		add_item(BYTE_C5, 1'b1);             // lone prefix as the whole text

		// Random text: mostly well-formed sequences with random content,
		// the rest broken sequences and plain noise.
		while (text_bytes.size() < 230) begin
			kind = $urandom_range(0, 9);
			case (kind)
				0, 1: add_item(8'($urandom_range(0, 8'hC2)), rand_fin());
				2, 3: begin
					add_item(BYTE_C3, rand_fin());
					clean = ($urandom_range(0, 4) != 0);
					add_item(clean ? 8'($urandom_range(8'h80, 8'hBF)) :
						8'($urandom_range(0, 255)), rand_fin());
				end
				4, 5: begin
					add_item(BYTE_C5, rand_fin());
					pick = $urandom_range(0, 3);
					if (pick == 0)
						add_item(BYTE_92, rand_fin());
					else if (pick == 1)
						add_item(BYTE_93, rand_fin());
					else
						add_item(8'($urandom_range(0, 255)), rand_fin());
				end
				6, 7: begin
					add_item(BYTE_E2, rand_fin());
					pick = $urandom_range(0, 5);
					if (pick < 5)
						add_item(BYTE_80, rand_fin());
					if (pick < 4)
						add_item(BYTE_99, rand_fin());
					else
						add_item(8'($urandom_range(0, 255)), rand_fin());
				end
				8: add_item(8'($urandom_range(0, 255)), rand_fin());
				default: add_item(8'($urandom_range(0, 255)), 1'b1);
			endcase
		end
		n_items = text_bytes.size();
		quiet_from = n_items - 40;
		text_built = 1'b1;

		// Hold reset, then release it for good.
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Drain: every item sent and every predicted byte seen.
		while (item_idx < n_items || waiting != 0)
			@(posedge clk);
		repeat (TailWait) @(posedge clk);

		if (fail_count == 0 && waiting == 0)
			$display("utf8_accent_folding verification clean");
		else
			$display("utf8_accent_folding verification failed");
		$finish;
	end

endmodule
